// File: design/cle_pkg.sv
// ============================================================================
// cle_pkg
// Shared types and codes of the circular list engine: pool size, index and
// count widths, operation codes and status codes.
// ============================================================================
package cle_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [2:0]              kind_t;
  typedef logic [1:0]              status_t;

  localparam kind_t KIND_INS_HEAD  = 3'd0;
  localparam kind_t KIND_INS_TAIL  = 3'd1;
  localparam kind_t KIND_INS_AFTER = 3'd2;
  localparam kind_t KIND_DEL_HEAD  = 3'd3;
  localparam kind_t KIND_DEL_TAIL  = 3'd4;
  localparam kind_t KIND_DEL_MATCH = 3'd5;
  localparam kind_t KIND_DISPLAY   = 3'd6;

  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_EMPTY    = 2'd1;
  localparam status_t STAT_NOTFOUND = 2'd2;
  localparam status_t STAT_FULL     = 2'd3;

endpackage

// File: design/cle_if.sv
// ============================================================================
// cle_if
// Valid/ready channels of the circular list engine: the operation channel
// and the result channel.
// ============================================================================
interface cle_in_if;
  import cle_pkg::*;

  logic   valid;
  logic   ready;
  kind_t  kind;
  value_t item_value;
  value_t match_value;

  modport source (output valid, output kind, output item_value, output match_value,
                  input ready);
  modport sink   (input valid, input kind, input item_value, input match_value,
                  output ready);
endinterface

interface cle_out_if;
  import cle_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  value_t  out_value;
  logic    is_last;

  modport source (output valid, output status, output out_value, output is_last,
                  input ready);
  modport sink   (input valid, input status, input out_value, input is_last,
                  output ready);
endinterface

// File: design/circular_list_engine.sv
// ============================================================================
// circular_list_engine
// Circular singly linked list of signed 32-bit values in a fixed node pool,
// with insert, delete, search and display operations walked through memory.
// ============================================================================
//
//   channel   direction  payload                           items per operation
//   in_ch     in         kind, item_value, match_value     1
//   out_ch    out        status, out_value, is_last        0 or 1 (display: 1..16)
//
// Node values and links sit in two memories with a registered read port; a
// walk follows one link per cycle unless a stalled result channel holds it.
// An insert into a non-empty list writes the new node and then, in a
// separate link write, points its predecessor at it; the unused code
// returns to idle with no result.
// Reset clears the in-use bits, tail and count at once; there is no clearing
// pass. A stalled result channel holds a display walk in place; other results
// wait in a result register while the next item is taken.
module circular_list_engine (
  input  logic      clk,
  input  logic      rst_n,
  cle_in_if.sink    in_ch,
  cle_out_if.source out_ch
);
  import cle_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_HEAD = 5'b00010,
    ST_WALK = 5'b00100,
    ST_FIX  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  // Node memories.
  value_t value_mem [CAPACITY];
  idx_t   link_mem  [CAPACITY];
  value_t rd_value_r;
  idx_t   rd_link_r;
  idx_t   raddr;
  logic   v_we;
  idx_t   v_waddr;
  value_t v_wdata;
  logic   l_we;
  idx_t   l_waddr;
  idx_t   l_wdata;

  state_t              state_r, state_nxt;
  kind_t               kind_r, kind_nxt;
  value_t              item_r, item_nxt;
  value_t              match_r, match_nxt;
  idx_t                tail_r, tail_nxt;
  cnt_t                count_r, count_nxt;
  logic [CAPACITY-1:0] in_use_r, in_use_nxt;
  idx_t                cur_r, cur_nxt;
  idx_t                prev_r, prev_nxt;
  cnt_t                idx_r, idx_nxt;
  idx_t                fix_addr_r, fix_addr_nxt;
  idx_t                fix_data_r, fix_data_nxt;
  status_t             res_status_r, res_status_nxt;
  value_t              res_value_r, res_value_nxt;

  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  value_t  out_value_r, out_value_nxt;
  logic    out_last_r, out_last_nxt;

  idx_t free_idx;
  logic out_free;
  logic push;
  logic walk_last;
  logic hit;
  logic ins_go;
  idx_t ins_p;
  logic rm_go;

  always_ff @(posedge clk) begin
    if (v_we) begin
      value_mem[v_waddr] <= v_wdata;
    end
    rd_value_r <= value_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      link_mem[l_waddr] <= l_wdata;
    end
    rd_link_r <= link_mem[raddr];
  end

  // Lowest-numbered free pool entry.
  always_comb begin
    free_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_idx = idx_t'(i);
      end
    end
  end

  assign out_free  = !out_valid_r || out_ch.ready;
  assign walk_last = ((idx_r + cnt_t'(1)) == count_r);
  assign hit = (kind_r == KIND_DEL_HEAD) ||
               ((kind_r == KIND_DEL_TAIL) && (cur_r == tail_r)) ||
               (((kind_r == KIND_INS_AFTER) || (kind_r == KIND_DEL_MATCH)) &&
                (rd_value_r == match_r));

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    item_nxt       = item_r;
    match_nxt      = match_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    in_use_nxt     = in_use_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    idx_nxt        = idx_r;
    fix_addr_nxt   = fix_addr_r;
    fix_data_nxt   = fix_data_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    raddr          = cur_r;
    v_we           = 1'b0;
    v_waddr        = free_idx;
    v_wdata        = item_r;
    l_we           = 1'b0;
    l_waddr        = free_idx;
    l_wdata        = rd_link_r;
    push           = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    ins_go         = 1'b0;
    ins_p          = cur_r;
    rm_go          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        raddr = tail_r;
        if (in_ch.valid) begin
          kind_nxt       = in_ch.kind;
          item_nxt       = in_ch.item_value;
          match_nxt      = in_ch.match_value;
          res_value_nxt  = '0;
          res_status_nxt = STAT_OK;
          unique case (in_ch.kind) inside
            KIND_INS_HEAD, KIND_INS_TAIL: begin
              if (count_r == cnt_t'(CAPACITY)) begin
                res_status_nxt = STAT_FULL;
                state_nxt      = ST_EMIT;
              end else if (count_r == '0) begin
                // First node links to itself and becomes the tail.
                v_we                 = 1'b1;
                v_wdata              = in_ch.item_value;
                l_we                 = 1'b1;
                l_wdata              = free_idx;
                in_use_nxt[free_idx] = 1'b1;
                count_nxt            = cnt_t'(1);
                tail_nxt             = free_idx;
                state_nxt            = ST_EMIT;
              end else begin
                state_nxt = ST_HEAD;
              end
            end
            KIND_INS_AFTER: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
                state_nxt      = ST_EMIT;
              end else if (count_r == cnt_t'(CAPACITY)) begin
                res_status_nxt = STAT_FULL;
                state_nxt      = ST_EMIT;
              end else begin
                state_nxt = ST_HEAD;
              end
            end
            KIND_DEL_HEAD, KIND_DEL_TAIL, KIND_DEL_MATCH, KIND_DISPLAY: begin
              if (count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
                state_nxt      = ST_EMIT;
              end else begin
                state_nxt = ST_HEAD;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_HEAD: begin
        // rd_link_r holds the tail's link, which is the head.
        if ((kind_r == KIND_INS_HEAD) || (kind_r == KIND_INS_TAIL)) begin
          ins_go = 1'b1;
          ins_p  = tail_r;
        end else begin
          raddr     = rd_link_r;
          cur_nxt   = rd_link_r;
          prev_nxt  = tail_r;
          idx_nxt   = '0;
          state_nxt = ST_WALK;
        end
      end

      ST_WALK: begin
        if (kind_r == KIND_DISPLAY) begin
          if (out_free) begin
            push           = 1'b1;
            out_status_nxt = STAT_OK;
            out_value_nxt  = rd_value_r;
            out_last_nxt   = walk_last;
            if (walk_last) begin
              state_nxt = ST_IDLE;
            end else begin
              raddr   = rd_link_r;
              cur_nxt = rd_link_r;
              idx_nxt = idx_r + cnt_t'(1);
            end
          end
        end else if (hit) begin
          if (kind_r == KIND_INS_AFTER) begin
            ins_go = 1'b1;
            ins_p  = cur_r;
          end else begin
            rm_go = 1'b1;
          end
        end else if (walk_last) begin
          res_status_nxt = STAT_NOTFOUND;
          state_nxt      = ST_EMIT;
        end else begin
          raddr    = rd_link_r;
          prev_nxt = cur_r;
          cur_nxt  = rd_link_r;
          idx_nxt  = idx_r + cnt_t'(1);
        end
      end

      ST_FIX: begin
        l_we      = 1'b1;
        l_waddr   = fix_addr_r;
        l_wdata   = fix_data_r;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          push           = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // New node after ins_p: its link copies ins_p's link now, and ins_p is
    // pointed at it in the next cycle (ST_FIX), since the link memory has one write port.
    if (ins_go) begin
      v_we                 = 1'b1;
      l_we                 = 1'b1;
      l_waddr              = free_idx;
      l_wdata              = rd_link_r;
      in_use_nxt[free_idx] = 1'b1;
      count_nxt            = count_r + cnt_t'(1);
      fix_addr_nxt         = ins_p;
      fix_data_nxt         = free_idx;
      if ((kind_r == KIND_INS_TAIL) ||
          ((kind_r == KIND_INS_AFTER) && (ins_p == tail_r))) begin
        tail_nxt = free_idx;
      end
      res_status_nxt = STAT_OK;
      res_value_nxt  = '0;
      state_nxt      = ST_FIX;
    end

    // Unlink cur_r, whose predecessor is prev_r.
    if (rm_go) begin
      res_status_nxt    = STAT_OK;
      res_value_nxt     = rd_value_r;
      in_use_nxt[cur_r] = 1'b0;
      if (count_r <= cnt_t'(1)) begin
        count_nxt = '0;
        tail_nxt  = '0;
      end else begin
        l_we      = 1'b1;
        l_waddr   = prev_r;
        l_wdata   = rd_link_r;
        count_nxt = count_r - cnt_t'(1);
        if (cur_r == tail_r) begin
          tail_nxt = prev_r;
        end
      end
      state_nxt = ST_EMIT;
    end

    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tail_r      <= '0;
      count_r     <= '0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    item_r       <= item_nxt;
    match_r      <= match_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    idx_r        <= idx_nxt;
    fix_addr_r   <= fix_addr_nxt;
    fix_data_r   <= fix_data_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.is_last   = out_last_r;

endmodule

// File: verif/cle_list_scoreboard_pkg.sv
// ============================================================================
// cle_list_scoreboard_pkg
// Scoreboard for the circular list engine. It keeps a shadow copy of the node
// pool, works out the results of each accepted operation and checks the
// results that leave the block, in order.
// ============================================================================
package cle_list_scoreboard_pkg;
  import cle_pkg::*;

  typedef struct {
    status_t status;
    value_t  value;
    logic    last;
  } list_result_t;

  class cle_list_scoreboard;
    value_t       node_val  [CAPACITY];
    idx_t         node_next [CAPACITY];
    bit           node_used [CAPACITY];
    idx_t         tail;
    int unsigned  count;
    list_result_t expected_q[$];
    int unsigned  mismatches;

    function new();
      foreach (node_val[i]) begin
        node_val[i]  = '0;
        node_next[i] = '0;
        node_used[i] = 1'b0;
      end
      tail       = '0;
      count      = 0;
      mismatches = 0;
    endfunction

    function void push_result(status_t s, value_t v, logic last);
      list_result_t r;
      r.status = s;
      r.value  = v;
      r.last   = last;
      expected_q.push_back(r);
    endfunction

    // New nodes always take the lowest free pool entry.
    function idx_t alloc_node(value_t v);
      for (int i = 0; i < CAPACITY; i++) begin
        if (!node_used[i]) begin
          node_used[i] = 1'b1;
          node_val[i]  = v;
          node_next[i] = idx_t'(i);
          count++;
          return idx_t'(i);
        end
      end
      return '0;
    endfunction

    // Walks from the head and returns the first node holding m and the node
    // in front of it.
    function bit find_first(value_t m, output idx_t at, output idx_t prev);
      idx_t p;
      prev = tail;
      p    = node_next[tail];
      at   = '0;
      for (int unsigned i = 0; i < count; i++) begin
        if (node_val[p] == m) begin
          at = p;
          return 1'b1;
        end
        prev = p;
        p    = node_next[p];
      end
      return 1'b0;
    endfunction

    function value_t unlink_node(idx_t p, idx_t prev);
      value_t v;
      v = node_val[p];
      if (count <= 1) begin
        count = 0;
        tail  = '0;
      end else begin
        node_next[prev] = node_next[p];
        if (p == tail) tail = prev;
        count--;
      end
      node_used[p] = 1'b0;
      return v;
    endfunction

    function void note_op(kind_t k, value_t iv, value_t mv);
      idx_t n;
      idx_t p;
      idx_t prev;
      case (k)
        KIND_INS_HEAD, KIND_INS_TAIL: begin
          if (count >= CAPACITY) begin
            push_result(STAT_FULL, '0, 1'b1);
          end else begin
            n = alloc_node(iv);
            if (count == 1) begin
              tail = n;
            end else begin
              node_next[n]    = node_next[tail];
              node_next[tail] = n;
              if (k == KIND_INS_TAIL) tail = n;
            end
            push_result(STAT_OK, '0, 1'b1);
          end
        end
        KIND_INS_AFTER: begin
          if (count == 0) begin
            push_result(STAT_EMPTY, '0, 1'b1);
          end else if (count >= CAPACITY) begin
            push_result(STAT_FULL, '0, 1'b1);
          end else if (!find_first(mv, p, prev)) begin
            push_result(STAT_NOTFOUND, '0, 1'b1);
          end else begin
            n            = alloc_node(iv);
            node_next[n] = node_next[p];
            node_next[p] = n;
            if (p == tail) tail = n;
            push_result(STAT_OK, '0, 1'b1);
          end
        end
        KIND_DEL_HEAD, KIND_DEL_TAIL: begin
          if (count == 0) begin
            push_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            if (k == KIND_DEL_HEAD) begin
              prev = tail;
              p    = node_next[tail];
            end else begin
              // The tail's predecessor is found by walking once around.
              p    = tail;
              prev = tail;
              for (int unsigned i = 1; i < count; i++) prev = node_next[prev];
            end
            push_result(STAT_OK, unlink_node(p, prev), 1'b1);
          end
        end
        KIND_DEL_MATCH: begin
          if (count == 0) begin
            push_result(STAT_EMPTY, '0, 1'b1);
          end else if (!find_first(mv, p, prev)) begin
            push_result(STAT_NOTFOUND, '0, 1'b1);
          end else begin
            push_result(STAT_OK, unlink_node(p, prev), 1'b1);
          end
        end
        KIND_DISPLAY: begin
          if (count == 0) begin
            push_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            p = node_next[tail];
            for (int unsigned i = 0; i < count; i++) begin
              push_result(STAT_OK, node_val[p], (i + 1 == count));
              p = node_next[p];
            end
          end
        end
        default: ;
      endcase
    endfunction

    // A value currently held somewhere in the list; the list must not be empty.
    function value_t pick_stored();
      int unsigned skip;
      skip = $urandom_range(count - 1, 0);
      foreach (node_used[i]) begin
        if (node_used[i]) begin
          if (skip == 0) return node_val[i];
          skip--;
        end
      end
      return '0;
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
    endfunction

    function void check_result(status_t s, value_t v, logic last);
      list_result_t e;
      if (expected_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result: status %0d value %0d last %0b",
                                s, v, last));
        return;
      end
      e = expected_q.pop_front();
      if (e.status !== s || e.value !== v || e.last !== last)
        note_mismatch($sformatf(
          "expected status %0d value %0d last %0b, got status %0d value %0d last %0b",
          e.status, e.value, e.last, s, v, last));
    endfunction
  endclass

endpackage

// File: verif/tb_circular_list_engine.sv
// ============================================================================
// tb_circular_list_engine
// Drives list operations into the circular list engine and checks every
// result item against the scoreboard: a directed pass over the empty, full
// and not-found cases, then random grow and shrink phases under changing
// handshake idling and one long result stall.
// ============================================================================
module tb_circular_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import cle_pkg::*;
  import cle_list_scoreboard_pkg::*;

  localparam kind_t  KIND_UNUSED  = 3'd7;
  localparam value_t VALUE_MAX    = 32'h7FFF_FFFF;
  localparam value_t VALUE_MIN    = 32'h8000_0000;
  localparam value_t VALUE_ABSENT = 32'sd12345;

  localparam int RANDOM_OPS   = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  // No item moves on either channel during the long stall; allow several
  // times that before calling it a hang.
  localparam int QUIET_LIMIT  = 2000;

  logic clk;
  logic rst_n;

  cle_in_if  in_ch();
  cle_out_if out_ch();

  circular_list_engine uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cle_list_scoreboard list_sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_request;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_op(kind_t k, value_t iv, value_t mv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= k;
    in_ch.item_value  <= iv;
    in_ch.match_value <= mv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    list_sb.note_op(k, iv, mv);
  endtask

  // Small values repeat often so that searches hit duplicates.
  function automatic value_t rand_value();
    case ($urandom_range(3))
      0:       return value_t'($urandom);
      1:       return $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
      default: return value_t'(int'($urandom_range(6)) - 3);
    endcase
  endfunction

  function automatic value_t rand_match();
    if (list_sb.count != 0 && $urandom_range(99) < 75) return list_sb.pick_stored();
    return rand_value();
  endfunction

  function automatic kind_t pick_kind(bit grow);
    int unsigned r;
    r = $urandom_range(99);
    if (r >= 98) return KIND_UNUSED;
    if (grow) begin
      if (r < 20) return KIND_INS_HEAD;
      if (r < 40) return KIND_INS_TAIL;
      if (r < 60) return KIND_INS_AFTER;
      if (r < 68) return KIND_DEL_HEAD;
      if (r < 76) return KIND_DEL_TAIL;
      if (r < 86) return KIND_DEL_MATCH;
      return KIND_DISPLAY;
    end
    if (r < 10) return KIND_INS_HEAD;
    if (r < 20) return KIND_INS_TAIL;
    if (r < 30) return KIND_INS_AFTER;
    if (r < 48) return KIND_DEL_HEAD;
    if (r < 66) return KIND_DEL_TAIL;
    if (r < 84) return KIND_DEL_MATCH;
    return KIND_DISPLAY;
  endfunction

  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        list_sb.check_result(out_ch.status, out_ch.out_value, out_ch.is_last);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL circular_list_engine");
    $finish;
  end

  initial begin : stimulus
    kind_t k;
    bit    grow;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= KIND_INS_HEAD;
    in_ch.item_value  <= '0;
    in_ch.match_value <= '0;
    rst_n             <= 1'b0;
    send_idle_pct = 25;
    recv_idle_pct = 68;
    hold_request  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Every delete, the display and insert after on an empty list, and the unused code.
    send_op(KIND_DISPLAY,   '0, '0);
    send_op(KIND_DEL_HEAD,  '0, '0);
    send_op(KIND_DEL_TAIL,  '0, '0);
    send_op(KIND_DEL_MATCH, '0, '0);
    send_op(KIND_INS_AFTER, 32'sd5, 32'sd5);
    send_op(KIND_UNUSED,    VALUE_MAX, VALUE_MIN);

    // Extreme values, insertion after the tail and searches that miss.
    send_op(KIND_INS_HEAD,  VALUE_MAX, '0);
    send_op(KIND_INS_TAIL,  VALUE_MIN, '0);
    send_op(KIND_INS_AFTER, '0, VALUE_MIN);
    send_op(KIND_INS_AFTER, 32'sd1, VALUE_ABSENT);
    send_op(KIND_DEL_MATCH, '0, VALUE_ABSENT);

    // Fill the pool, then hit it with every kind of insert.
    for (int i = 0; i < CAPACITY - 3; i++)
      send_op((i % 2 == 0) ? KIND_INS_HEAD : KIND_INS_TAIL, value_t'($urandom), '0);
    send_op(KIND_INS_HEAD,  32'sd7, '0);
    send_op(KIND_INS_TAIL,  32'sd7, '0);
    send_op(KIND_INS_AFTER, 32'sd7, VALUE_MAX);
    send_op(KIND_DISPLAY,   '0, '0);
    send_op(KIND_DEL_MATCH, '0, VALUE_MIN);
    send_op(KIND_DEL_TAIL,  '0, '0);
    send_op(KIND_DEL_HEAD,  '0, '0);

    // Alternating grow and shrink phases walk the list between empty and full.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == RANDOM_OPS / 3) begin
        send_idle_pct = 68;
        recv_idle_pct = 25;
      end
      if (i == 2 * RANDOM_OPS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == 2 * RANDOM_OPS / 3 + 40) hold_request = 1'b1;
      grow = ((i / 50) % 2) == 0;
      k    = pick_kind(grow);
      send_op(k, rand_value(), rand_match());
    end
    in_ch.valid <= 1'b0;

    while (list_sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (list_sb.mismatches == 0 && list_sb.expected_q.size() == 0)
      $display("PASS circular_list_engine");
    else
      $display("FAIL circular_list_engine");
    $finish;
  end

endmodule

// File: filelist.f
design/cle_pkg.sv
design/cle_if.sv
design/circular_list_engine.sv
verif/cle_list_scoreboard_pkg.sv
verif/tb_circular_list_engine.sv
